>>> design/jddm_pkg.sv
`default_nettype none
package jddm_pkg;

    localparam int JOY_W      = 8;
    localparam int JOY_LIMIT  = 100;
    localparam int ABS_W      = 7;
    localparam int FULL_DEFL  = 100;
    localparam int HALF_DEFL  = 50;
    localparam int BEND_W     = 6;
    localparam int SQ_W       = 14;
    localparam int SUM_W      = 15;
    localparam int NUM_W      = 12;
    localparam int FACTOR_DEN = 2500;
    localparam int MAG_W      = 8;
    localparam int PROD_W     = 19;
    localparam int SPEED_W    = 9;

    // floor(p / 2500) == (p * RECIP) >> 32, exact for p < 2^19
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1717987;

    // steering numerators are carried as magnitude plus sign
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [NUM_W-1:0] lnum;
        logic             lneg;
        logic [NUM_W-1:0] rnum;
        logic             rneg;
    } steer_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] lnum;
        logic             lneg;
        logic [NUM_W-1:0] rnum;
        logic             rneg;
    } mix_t;

endpackage
`default_nettype wire

>>> design/jddm_steer.sv
`default_nettype none
module jddm_steer
    import jddm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [JOY_W-1:0] joy_y,
    input  wire logic signed [JOY_W-1:0] joy_x,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output steer_t                       out_data
);

    logic signed [JOY_W-1:0] yc;
    logic signed [JOY_W-1:0] xc;
    logic [ABS_W-1:0]        yabs;
    logic [ABS_W-1:0]        xabs;
    logic                    en_a;
    logic                    en_b;

    logic                    va_reg;
    logic [ABS_W-1:0]        ya_reg;
    logic [ABS_W-1:0]        xa_reg;
    logic                    xneg_reg;
    logic                    far_reg;
    logic [BEND_W-1:0]       bend_reg;

    logic                    vb_reg;
    steer_t                  data_next;
    steer_t                  data_reg;

    logic [SQ_W-1:0]         ysq;
    logic [SQ_W-1:0]         xsq;
    logic [NUM_W-1:0]        bsq;
    logic [NUM_W-1:0]        anum;
    logic                    xpos;

    assign en_b     = !vb_reg || !out_stall;
    assign en_a     = !va_reg || en_b;
    assign in_stall = !en_a;

    always_comb
    begin
        if (joy_y > JOY_W'(JOY_LIMIT))
            yc = JOY_W'(JOY_LIMIT);
        else if (joy_y < -JOY_W'(JOY_LIMIT))
            yc = -JOY_W'(JOY_LIMIT);
        else
            yc = joy_y;
        if (joy_x > JOY_W'(JOY_LIMIT))
            xc = JOY_W'(JOY_LIMIT);
        else if (joy_x < -JOY_W'(JOY_LIMIT))
            xc = -JOY_W'(JOY_LIMIT);
        else
            xc = joy_x;
        yabs = yc[JOY_W-1] ? ABS_W'(-yc) : ABS_W'(yc);
        xabs = xc[JOY_W-1] ? ABS_W'(-xc) : ABS_W'(xc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
        end
    end

    // beyond half deflection the quadratic is 2500 - (100-|x|)^2, negated
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            ya_reg   <= yabs;
            xa_reg   <= xabs;
            xneg_reg <= xc[JOY_W-1];
            far_reg  <= (xabs > ABS_W'(HALF_DEFL));
            bend_reg <= (xabs > ABS_W'(HALF_DEFL)) ? BEND_W'(ABS_W'(FULL_DEFL) - xabs)
                                                   : BEND_W'(xabs);
        end
        if (en_b)
            data_reg <= data_next;
    end

    always_comb
    begin
        ysq  = SQ_W'(ya_reg) * SQ_W'(ya_reg);
        xsq  = SQ_W'(xa_reg) * SQ_W'(xa_reg);
        bsq  = NUM_W'(bend_reg) * NUM_W'(bend_reg);
        anum = NUM_W'(FACTOR_DEN) - bsq;
        xpos = !xneg_reg && (xa_reg != '0);

        data_next.sum = SUM_W'(ysq) + SUM_W'(xsq);
        if (xneg_reg)
        begin
            data_next.lnum = anum;
            data_next.lneg = far_reg;
        end
        else
        begin
            data_next.lnum = NUM_W'(FACTOR_DEN);
            data_next.lneg = 1'b0;
        end
        if (xpos)
        begin
            data_next.rnum = anum;
            data_next.rneg = far_reg;
        end
        else
        begin
            data_next.rnum = NUM_W'(FACTOR_DEN);
            data_next.rneg = 1'b0;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> design/jddm_isqrt.sv
`default_nettype none
module jddm_isqrt
    import jddm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire steer_t in_data,
    output logic        out_valid,
    input  wire logic   out_stall,
    output mix_t        out_data
);

    localparam int REM_W  = 11;
    localparam int RAD_W  = 2 * MAG_W;
    localparam int HALF_N = MAG_W / 2;
    localparam int LOW_W  = RAD_W / 2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } sq_t;

    // one restoring digit: bring down two radicand bits, try 4*root+1
    function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        sq_t              nxt;
        r     = {cur.rem[REM_W-3:0], pair};
        trial = REM_W'({cur.root, 2'b01});
        if (r >= trial)
        begin
            nxt.rem  = r - trial;
            nxt.root = {cur.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = r;
            nxt.root = {cur.root[MAG_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    logic             en_a;
    logic             en_b;
    logic [RAD_W-1:0] rad;
    sq_t              hi_next;
    sq_t              lo_next;

    logic             va_reg;
    sq_t              hi_reg;
    logic [LOW_W-1:0] low_reg;
    steer_t           pass_reg;

    logic             vb_reg;
    mix_t             data_reg;

    assign en_b     = !vb_reg || !out_stall;
    assign en_a     = !va_reg || en_b;
    assign in_stall = !en_a;
    assign rad      = RAD_W'(in_data.sum);

    always_comb
    begin
        hi_next = '0;
        for (int i = 0; i < HALF_N; i++)
            hi_next = sq_step(hi_next, rad[RAD_W-1-2*i -: 2]);
        lo_next = hi_reg;
        for (int i = 0; i < HALF_N; i++)
            lo_next = sq_step(lo_next, low_reg[LOW_W-1-2*i -: 2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            hi_reg   <= hi_next;
            low_reg  <= rad[LOW_W-1:0];
            pass_reg <= in_data;
        end
        if (en_b)
        begin
            data_reg.mag  <= lo_next.root;
            data_reg.lnum <= pass_reg.lnum;
            data_reg.lneg <= pass_reg.lneg;
            data_reg.rnum <= pass_reg.rnum;
            data_reg.rneg <= pass_reg.rneg;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> design/jddm_scale.sv
`default_nettype none
module jddm_scale
    import jddm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mix_t              in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [SPEED_W-1:0]     left_speed,
    output logic [SPEED_W-1:0]     right_speed
);

    localparam int WIDE_W = PROD_W + RECIP_W;

    logic               en_a;
    logic               en_b;
    logic               en_c;

    logic               va_reg;
    logic [PROD_W-1:0]  lprod_reg;
    logic [PROD_W-1:0]  rprod_reg;
    logic               lneg_a_reg;
    logic               rneg_a_reg;

    logic               vb_reg;
    logic [WIDE_W-1:0]  lwide;
    logic [WIDE_W-1:0]  rwide;
    logic [MAG_W-1:0]   lq_reg;
    logic [MAG_W-1:0]   rq_reg;
    logic               lneg_b_reg;
    logic               rneg_b_reg;

    logic               vc_reg;
    logic [SPEED_W-1:0] left_next;
    logic [SPEED_W-1:0] right_next;
    logic [SPEED_W-1:0] left_reg;
    logic [SPEED_W-1:0] right_reg;

    assign en_c     = !vc_reg || !out_stall;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_stall = !en_a;

    assign lwide = WIDE_W'(lprod_reg) * WIDE_W'(RECIP);
    assign rwide = WIDE_W'(rprod_reg) * WIDE_W'(RECIP);

    // truncation toward zero: divide the magnitude, then restore the sign
    assign left_next  = lneg_b_reg ? SPEED_W'(0) - SPEED_W'(lq_reg) : SPEED_W'(lq_reg);
    assign right_next = rneg_b_reg ? SPEED_W'(0) - SPEED_W'(rq_reg) : SPEED_W'(rq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
            if (en_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            lprod_reg  <= PROD_W'(in_data.mag) * PROD_W'(in_data.lnum);
            rprod_reg  <= PROD_W'(in_data.mag) * PROD_W'(in_data.rnum);
            lneg_a_reg <= in_data.lneg;
            rneg_a_reg <= in_data.rneg;
        end
        if (en_b)
        begin
            lq_reg     <= lwide[RECIP_SHIFT +: MAG_W];
            rq_reg     <= rwide[RECIP_SHIFT +: MAG_W];
            lneg_b_reg <= lneg_a_reg;
            rneg_b_reg <= rneg_a_reg;
        end
        if (en_c)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_valid   = vc_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;

endmodule
`default_nettype wire

>>> design/joystick_differential_drive_mixer_unit.sv
// Joystick mixer for a differential drive: each transaction carries one clamped
// joystick sample and returns one left/right motor speed pair, speed =
// floor(sqrt(y^2+x^2)) * steering factor, truncated toward zero. Seven register
// stages (clamp, squares and steering numerators, two four-bit square root
// stages, product, reciprocal divide by 2500, sign and output register) give a
// throughput of one transaction per cycle while speed_stall is low; each
// stage holds its item only while the stage after it is full, so bubbles are
// squeezed out under speed_stall and the input stalls only when all seven are
// occupied.
`default_nettype none
module joystick_differential_drive_mixer_unit
    import jddm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      joy_valid,
    output logic                           joy_stall,
    input  wire logic signed [JOY_W-1:0]   joy_y,
    input  wire logic signed [JOY_W-1:0]   joy_x,
    output logic                           speed_valid,
    input  wire logic                      speed_stall,
    output logic signed [SPEED_W-1:0]      left_speed,
    output logic signed [SPEED_W-1:0]      right_speed
);

    logic   steer_valid;
    logic   steer_stall;
    steer_t steer_data;
    logic   mix_valid;
    logic   mix_stall;
    mix_t   mix_data;

    jddm_steer u_steer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (joy_valid),
        .in_stall  (joy_stall),
        .joy_y     (joy_y),
        .joy_x     (joy_x),
        .out_valid (steer_valid),
        .out_stall (steer_stall),
        .out_data  (steer_data)
    );

    jddm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (steer_valid),
        .in_stall  (steer_stall),
        .in_data   (steer_data),
        .out_valid (mix_valid),
        .out_stall (mix_stall),
        .out_data  (mix_data)
    );

    jddm_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mix_valid),
        .in_stall    (mix_stall),
        .in_data     (mix_data),
        .out_valid   (speed_valid),
        .out_stall   (speed_stall),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    // input backs up only once the whole pipe is full behind a stalled result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        joy_stall |-> (speed_valid && speed_stall && mix_stall && steer_stall))
        else $error("input stalled while pipeline has room");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_valid |-> (left_speed >= -SPEED_W'(141) && left_speed <= SPEED_W'(141)
                      && right_speed >= -SPEED_W'(141) && right_speed <= SPEED_W'(141)))
        else $error("motor speed outside full-scale range");

    // only one side can reverse for a given steering position
    a_one_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_valid && left_speed[SPEED_W-1]) |-> !right_speed[SPEED_W-1])
        else $error("both motors reversing");

endmodule
`default_nettype wire

>>> tb/sv/joystick_differential_drive_mixer_unit_test.sv
`default_nettype none
module joystick_differential_drive_mixer_unit_test;
    import jddm_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic signed [JOY_W-1:0]   y;
        logic signed [JOY_W-1:0]   x;
        logic signed [SPEED_W-1:0] lspd;
        logic signed [SPEED_W-1:0] rspd;
    } speed_pair_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      joy_valid = 1'b0;
    logic                      joy_stall;
    logic signed [JOY_W-1:0]   joy_y = '0;
    logic signed [JOY_W-1:0]   joy_x = '0;
    logic                      speed_valid;
    logic                      speed_stall = 1'b0;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;

    speed_pair_t pending_speeds[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int samples_sent = 0;
    int speeds_checked = 0;
    int quiet_cycles = 0;

    joystick_differential_drive_mixer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .joy_valid   (joy_valid),
        .joy_stall   (joy_stall),
        .joy_y       (joy_y),
        .joy_x       (joy_x),
        .speed_valid (speed_valid),
        .speed_stall (speed_stall),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    always #1 clk = ~clk;

    function automatic int clamp_position(input logic signed [JOY_W-1:0] raw);
        int v;
        v = raw;
        if (v > JOY_LIMIT)
            v = JOY_LIMIT;
        else if (v < -JOY_LIMIT)
            v = -JOY_LIMIT;
        return v;
    endfunction

    function automatic speed_pair_t mix_speeds(input logic signed [JOY_W-1:0] y_raw,
                                               input logic signed [JOY_W-1:0] x_raw);
        speed_pair_t res;
        int y;
        int x;
        int sq;
        int mag;
        int lnum;
        int rnum;
        y = clamp_position(y_raw);
        x = clamp_position(x_raw);
        sq = y * y + x * x;
        mag = 0;
        while ((mag + 1) * (mag + 1) <= sq)
            mag++;
        if (x < -HALF_DEFL)
            lnum = x * x + 200 * x + 7500;
        else if (x < 0)
            lnum = FACTOR_DEN - x * x;
        else
            lnum = FACTOR_DEN;
        if (x > HALF_DEFL)
            rnum = x * x - 200 * x + 7500;
        else if (x > 0)
            rnum = FACTOR_DEN - x * x;
        else
            rnum = FACTOR_DEN;
        res.y = y_raw;
        res.x = x_raw;
        // int division truncates toward zero, as the block must
        res.lspd = SPEED_W'((mag * lnum) / FACTOR_DEN);
        res.rspd = SPEED_W'((mag * rnum) / FACTOR_DEN);
        return res;
    endfunction

    function automatic logic signed [JOY_W-1:0] pick_position();
        int sel;
        int bends[11] = '{-100, -51, -50, -49, -1, 0, 1, 49, 50, 51, 100};
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return JOY_W'($urandom);
        else if (sel == 1)
            return JOY_W'(bends[$urandom_range(0, 10)]);
        else
            return JOY_W'($urandom_range(0, 2 * JOY_LIMIT) - JOY_LIMIT);
    endfunction

    // called at a rising edge; returns at the edge the transaction is accepted
    task automatic send_sample(input int y, input int x);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            joy_valid <= 1'b0;
            @(posedge clk);
        end
        joy_valid <= 1'b1;
        joy_y <= JOY_W'(y);
        joy_x <= JOY_W'(x);
        do
            @(posedge clk);
        while (joy_stall);
        pending_speeds.insert(pending_speeds.size(), mix_speeds(JOY_W'(y), JOY_W'(x)));
        samples_sent++;
    endtask

    task automatic drain_results();
        joy_valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_burst(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
            send_sample(pick_position(), pick_position());
        stall_pct = 0;
        drain_results();
    endtask

    task automatic test_directed();
        // corners, out-of-range saturation and every bend of the steering curves
        int dir_y[25] = '{0, 100, -100, 0, 0, 100, -100, 100, -100, 127, -128, 127, -128,
                          50, 50, 50, 50, 50, 50, 50, 50, 101, -101, 0, 3};
        int dir_x[25] = '{0, 0, 0, 100, -100, 100, -100, -100, 100, 127, -128, -128, 127,
                          -51, -50, -49, -1, 1, 49, 50, 51, -101, 101, -1, 4};
        idle_pct = 0;
        stall_pct = 0;
        foreach (dir_y[i])
            send_sample(dir_y[i], dir_x[i]);
        drain_results();
    endtask

    task automatic test_no_idling();
        send_random_burst(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_sender_idle();
        send_random_burst(PHASE_ITEMS, 55, 0);
    endtask

    task automatic test_receiver_stall();
        send_random_burst(PHASE_ITEMS, 0, 55);
    endtask

    task automatic test_both_idle();
        send_random_burst(PHASE_ITEMS, 22, 22);
    endtask

    always @(posedge clk)
        speed_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        speed_pair_t exp;
        if (rst_n && speed_valid && !speed_stall)
        begin
            speeds_checked++;
            if (pending_speeds.size() == 0)
            begin
                $display("%0t: unexpected speed pair left %0d right %0d", $time,
                         left_speed, right_speed);
                fail_count++;
            end
            else
            begin
                exp = pending_speeds.pop_front();
                if (left_speed !== exp.lspd)
                begin
                    $display("%0t: left_speed for y %0d x %0d: expected %0d, actual %0d",
                             $time, exp.y, exp.x, exp.lspd, left_speed);
                    fail_count++;
                end
                if (right_speed !== exp.rspd)
                begin
                    $display("%0t: right_speed for y %0d x %0d: expected %0d, actual %0d",
                             $time, exp.y, exp.x, exp.rspd, right_speed);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((joy_valid && !joy_stall) || (speed_valid && !speed_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     pending_speeds.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        if (pending_speeds.size() != 0)
        begin
            $display("%0t: %0d expected speed pairs never arrived", $time,
                     pending_speeds.size());
            fail_count++;
        end
        $display("Sent %0d joystick samples, checked %0d speed pairs", samples_sent,
                 speeds_checked);
        $display("Covered saturation, steering bends, sender gaps and receiver back-pressure");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
